/* rtl/fvtsm_pkg.sv */
// ----------------------------------------------------------------------------
// Four-voice tone sequencer and mixer: shared definitions
// Request codes, sequencer states and mixing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package fvtsm_pkg;

    // Request codes carried on the operation field.
    localparam logic [2:0] OP_TICK         = 3'd0;
    localparam logic [2:0] OP_START_SCORE  = 3'd1;
    localparam logic [2:0] OP_START_EFFECT = 3'd2;
    localparam logic [2:0] OP_WRITE_SCORE  = 3'd3;
    localparam logic [2:0] OP_WRITE_EFFECT = 3'd4;

    localparam int IDX_W   = 10;
    localparam int OP_W    = 3;
    localparam int WORD_W  = 16;
    localparam int MIX_W   = 10;
    localparam int ENTRY_W = 34;

    // Delay value that marks a stop (or a loop point) in both stores.
    localparam logic [WORD_W-1:0] STOP_MARK = 16'hFFFF;

    // A square voice adds 0x80 while its phase MSB is set; mono triples it.
    localparam logic [MIX_W-1:0] NOTE_WEIGHT = 10'd128;
    localparam logic [MIX_W-1:0] MONO_WEIGHT = 10'd384;

    localparam logic [1:0] FX_VOICE = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE,
        S_PHASE,
        S_SC_CHK,
        S_SC_EVAL,
        S_FX_CHK,
        S_FX_EVAL0,
        S_FX_EVAL1,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

/* rtl/four_voice_tone_sequencer_mixer_top.sv */
// ----------------------------------------------------------------------------
// Four-voice tone sequencer and mixer
// Three square voices and one sawtooth voice, driven by a score sequencer and
// an effect sequencer, mixed into one 8-bit sample per tick request.
// ----------------------------------------------------------------------------
// A tick request occupies the block until its sample is loaded: one shared
// 16-bit adder advances the four phase accumulators one voice per cycle
// (voices 1 and 2 are held in mono mode), after which each store is read
// through its single port (up to two score entries and two effect words per
// tick). Start and store-write requests hold the block while the index is
// reduced modulo the store depth by repeated subtraction. The
// sample is held in an output register, so a new request is taken while a
// finished sample still waits; a tick that finishes before that sample is
// taken waits in its last state. The stores are not cleared by reset.
`default_nettype none

module four_voice_tone_sequencer_mixer_top #(
    parameter int SCORE_DEPTH  = 1024,
    parameter int EFFECT_DEPTH = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [fvtsm_pkg::OP_W-1:0]    i_operation,
    input  wire logic                          i_mono_mode,
    input  wire logic                          i_loop_score,
    input  wire logic [fvtsm_pkg::IDX_W-1:0]   i_start_index,
    input  wire logic [fvtsm_pkg::IDX_W-1:0]   i_entry_index,
    input  wire logic [fvtsm_pkg::WORD_W-1:0]  i_event_delay,
    input  wire logic [1:0]                    i_event_voice,
    input  wire logic [fvtsm_pkg::WORD_W-1:0]  i_event_step,
    input  wire logic [fvtsm_pkg::WORD_W-1:0]  i_effect_word,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [7:0]                         o_sample,
    output logic                               o_score_active,
    output logic                               o_effect_active
);
    import fvtsm_pkg::*;

    localparam int SA_W = $clog2(SCORE_DEPTH);
    localparam int EA_W = $clog2(EFFECT_DEPTH);
    localparam logic [16:0] SC_LIM17 = 17'(SCORE_DEPTH);
    localparam logic [16:0] FX_LIM17 = 17'(EFFECT_DEPTH);
    localparam logic [SA_W:0] SC_LIM = (SA_W+1)'(SCORE_DEPTH);
    localparam logic [EA_W:0] FX_LIM = (EA_W+1)'(EFFECT_DEPTH);

    // Control state
    t_state              r_state, n_state;
    logic [1:0]          r_vidx, n_vidx;
    logic [MIX_W-1:0]    r_mix, n_mix;
    logic [WORD_W-1:0]   r_phase [4];
    logic [WORD_W-1:0]   n_phase [4];
    logic [WORD_W-1:0]   r_step [4];
    logic [WORD_W-1:0]   n_step [4];
    logic [31:0]         r_sc_elapsed, n_sc_elapsed;
    logic [WORD_W-1:0]   r_sc_wait, n_sc_wait;
    logic [SA_W-1:0]     r_sc_ptr, n_sc_ptr;
    logic [SA_W-1:0]     r_sc_origin, n_sc_origin;
    logic                r_sc_playing, n_sc_playing;
    logic                r_mono, n_mono;
    logic                r_loop, n_loop;
    logic                r_sc_reads, n_sc_reads;
    logic [31:0]         r_fx_elapsed, n_fx_elapsed;
    logic [WORD_W-1:0]   r_fx_wait, n_fx_wait;
    logic [EA_W-1:0]     r_fx_ptr, n_fx_ptr;
    logic                r_fx_playing, n_fx_playing;
    logic [IDX_W-1:0]    r_addr, n_addr;
    logic                r_out_valid, n_out_valid;

    // Payload registers
    logic [OP_W-1:0]     r_req_op;
    logic                r_req_mono;
    logic                r_req_loop;
    logic [WORD_W-1:0]   r_req_delay;
    logic [1:0]          r_req_voice;
    logic [WORD_W-1:0]   r_req_step;
    logic [WORD_W-1:0]   r_req_word;
    logic [7:0]          r_sample;
    logic                r_sc_act;
    logic                r_fx_act;
    logic [ENTRY_W-1:0]  r_sc_q;
    logic [WORD_W-1:0]   r_fx_q;

    // Stores
    logic [ENTRY_W-1:0]  sc_mem [SCORE_DEPTH];
    logic [WORD_W-1:0]   fx_mem [EFFECT_DEPTH];

    logic                in_accept;
    logic                out_accept;
    logic                out_load;
    logic                sc_we, sc_re, fx_we, fx_re;
    logic [SA_W-1:0]     sc_raddr;
    logic [EA_W-1:0]     fx_raddr;
    logic [16:0]         addr_ext;
    logic [16:0]         addr_lim;
    logic                addr_score;
    logic [SA_W:0]       sc_ptr_sum;
    logic [SA_W-1:0]     sc_ptr_inc;
    logic [EA_W:0]       fx_sum1, fx_sum2;
    logic [EA_W-1:0]     fx_ptr_inc1, fx_ptr_inc2;
    logic [WORD_W-1:0]   phase_sum;
    logic                voice_skip;

    assign in_accept  = i_valid && !o_stall;
    assign out_accept = r_out_valid && !i_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_sample        = r_sample;
    assign o_score_active  = r_sc_act;
    assign o_effect_active = r_fx_act;

    assign addr_ext   = {7'd0, r_addr};
    assign addr_score = (r_req_op == OP_START_SCORE) || (r_req_op == OP_WRITE_SCORE);
    assign addr_lim   = addr_score ? SC_LIM17 : FX_LIM17;

    // Pointer wrap at the store depth; the pointer is always below the depth.
    always_comb begin
        sc_ptr_sum = {1'b0, r_sc_ptr} + (SA_W+1)'(1);
        if (sc_ptr_sum >= SC_LIM) begin
            sc_ptr_sum = sc_ptr_sum - SC_LIM;
        end
        sc_ptr_inc = sc_ptr_sum[SA_W-1:0];
        fx_sum1 = {1'b0, r_fx_ptr} + (EA_W+1)'(1);
        if (fx_sum1 >= FX_LIM) begin
            fx_sum1 = fx_sum1 - FX_LIM;
        end
        fx_sum2 = {1'b0, r_fx_ptr} + (EA_W+1)'(2);
        if (fx_sum2 >= FX_LIM) begin
            fx_sum2 = fx_sum2 - FX_LIM;
        end
        fx_ptr_inc1 = fx_sum1[EA_W-1:0];
        fx_ptr_inc2 = fx_sum2[EA_W-1:0];
    end

    // The shared phase adder serves one voice per cycle.
    assign phase_sum  = r_phase[r_vidx] + r_step[r_vidx];
    assign voice_skip = r_mono && ((r_vidx == 2'd1) || (r_vidx == 2'd2));

    always_comb begin
        n_state      = r_state;
        n_vidx       = r_vidx;
        n_mix        = r_mix;
        n_phase      = r_phase;
        n_step       = r_step;
        n_sc_elapsed = r_sc_elapsed;
        n_sc_wait    = r_sc_wait;
        n_sc_ptr     = r_sc_ptr;
        n_sc_origin  = r_sc_origin;
        n_sc_playing = r_sc_playing;
        n_mono       = r_mono;
        n_loop       = r_loop;
        n_sc_reads   = r_sc_reads;
        n_fx_elapsed = r_fx_elapsed;
        n_fx_wait    = r_fx_wait;
        n_fx_ptr     = r_fx_ptr;
        n_fx_playing = r_fx_playing;
        n_addr       = r_addr;
        n_out_valid  = r_out_valid && !out_accept;
        out_load     = 1'b0;
        sc_we        = 1'b0;
        sc_re        = 1'b0;
        fx_we        = 1'b0;
        fx_re        = 1'b0;
        sc_raddr     = r_sc_ptr;
        fx_raddr     = r_fx_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    unique case (i_operation)
                        OP_TICK: begin
                            n_sc_elapsed = r_sc_elapsed + 32'd1;
                            n_fx_elapsed = r_fx_elapsed + 32'd1;
                            n_vidx       = 2'd0;
                            n_mix        = '0;
                            n_state      = S_PHASE;
                        end
                        OP_START_SCORE, OP_START_EFFECT: begin
                            n_addr  = i_start_index;
                            n_state = S_REDUCE;
                        end
                        OP_WRITE_SCORE, OP_WRITE_EFFECT: begin
                            n_addr  = i_entry_index;
                            n_state = S_REDUCE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_REDUCE: begin
                if (addr_ext >= addr_lim) begin
                    n_addr = r_addr - addr_lim[IDX_W-1:0];
                end else begin
                    n_state = S_IDLE;
                    case (r_req_op)
                        OP_START_SCORE: begin
                            n_sc_ptr     = addr_ext[SA_W-1:0];
                            n_sc_origin  = addr_ext[SA_W-1:0];
                            n_sc_wait    = '0;
                            n_sc_playing = 1'b1;
                            n_mono       = r_req_mono;
                            n_loop       = r_req_loop;
                            for (int v = 0; v < 3; v++) begin
                                n_phase[v] = '0;
                                n_step[v]  = '0;
                            end
                        end
                        OP_START_EFFECT: begin
                            n_fx_ptr     = addr_ext[EA_W-1:0];
                            n_fx_wait    = '0;
                            n_fx_playing = 1'b1;
                        end
                        OP_WRITE_SCORE: begin
                            sc_we = 1'b1;
                        end
                        default: begin
                            fx_we = 1'b1;
                        end
                    endcase
                end
            end

            S_PHASE: begin
                if (r_vidx == FX_VOICE) begin
                    n_mix = r_mix + {1'b0, r_phase[FX_VOICE][15:7]};
                end else if (!voice_skip && r_phase[r_vidx][15]) begin
                    n_mix = r_mix + (r_mono ? MONO_WEIGHT : NOTE_WEIGHT);
                end
                if (!voice_skip) begin
                    n_phase[r_vidx] = phase_sum;
                end
                n_vidx = r_vidx + 2'd1;
                if (r_vidx == FX_VOICE) begin
                    n_sc_reads = 1'b0;
                    n_state    = S_SC_CHK;
                end
            end

            S_SC_CHK: begin
                if (r_sc_playing && (r_sc_elapsed > {16'd0, r_sc_wait})) begin
                    sc_re   = 1'b1;
                    n_state = S_SC_EVAL;
                end else begin
                    n_state = S_FX_CHK;
                end
            end

            S_SC_EVAL: begin
                n_state = S_FX_CHK;
                if (r_sc_q[15:0] == STOP_MARK) begin
                    if (r_loop) begin
                        n_sc_ptr = r_sc_origin;
                        // A loop point gets one retry in the same tick.
                        if (!r_sc_reads) begin
                            n_sc_reads = 1'b1;
                            n_state    = S_SC_CHK;
                        end
                    end else begin
                        n_sc_playing = 1'b0;
                        for (int v = 0; v < 3; v++) begin
                            n_phase[v] = '0;
                            n_step[v]  = '0;
                        end
                    end
                end else begin
                    n_sc_elapsed            = '0;
                    n_sc_wait               = r_sc_q[15:0];
                    n_step[r_sc_q[17:16]]   = r_sc_q[33:18];
                    n_sc_ptr                = sc_ptr_inc;
                end
            end

            S_FX_CHK: begin
                if (r_fx_playing && (r_fx_elapsed > {16'd0, r_fx_wait})) begin
                    fx_re   = 1'b1;
                    n_state = S_FX_EVAL0;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_FX_EVAL0: begin
                n_fx_elapsed = '0;
                n_fx_wait    = r_fx_q;
                if (r_fx_q == STOP_MARK) begin
                    n_fx_playing      = 1'b0;
                    n_phase[FX_VOICE] = '0;
                    n_step[FX_VOICE]  = '0;
                    n_fx_ptr          = fx_ptr_inc2;
                    n_state           = S_DONE;
                end else begin
                    fx_re    = 1'b1;
                    fx_raddr = fx_ptr_inc1;
                    n_state  = S_FX_EVAL1;
                end
            end

            S_FX_EVAL1: begin
                n_step[FX_VOICE] = r_fx_q;
                n_fx_ptr         = fx_ptr_inc2;
                n_state          = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || out_accept) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_vidx       <= '0;
            r_mix        <= '0;
            for (int v = 0; v < 4; v++) begin
                r_phase[v] <= '0;
                r_step[v]  <= '0;
            end
            r_sc_elapsed <= '0;
            r_sc_wait    <= '0;
            r_sc_ptr     <= '0;
            r_sc_origin  <= '0;
            r_sc_playing <= 1'b0;
            r_mono       <= 1'b0;
            r_loop       <= 1'b0;
            r_sc_reads   <= 1'b0;
            r_fx_elapsed <= '0;
            r_fx_wait    <= '0;
            r_fx_ptr     <= '0;
            r_fx_playing <= 1'b0;
            r_addr       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_vidx       <= n_vidx;
            r_mix        <= n_mix;
            r_phase      <= n_phase;
            r_step       <= n_step;
            r_sc_elapsed <= n_sc_elapsed;
            r_sc_wait    <= n_sc_wait;
            r_sc_ptr     <= n_sc_ptr;
            r_sc_origin  <= n_sc_origin;
            r_sc_playing <= n_sc_playing;
            r_mono       <= n_mono;
            r_loop       <= n_loop;
            r_sc_reads   <= n_sc_reads;
            r_fx_elapsed <= n_fx_elapsed;
            r_fx_wait    <= n_fx_wait;
            r_fx_ptr     <= n_fx_ptr;
            r_fx_playing <= n_fx_playing;
            r_addr       <= n_addr;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req_op    <= i_operation;
            r_req_mono  <= i_mono_mode;
            r_req_loop  <= i_loop_score;
            r_req_delay <= i_event_delay;
            r_req_voice <= i_event_voice;
            r_req_step  <= i_event_step;
            r_req_word  <= i_effect_word;
        end
        if (out_load) begin
            r_sample <= r_mix[9:2];
            r_sc_act <= r_sc_playing;
            r_fx_act <= r_fx_playing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sc_we) begin
            sc_mem[addr_ext[SA_W-1:0]] <= {r_req_step, r_req_voice, r_req_delay};
        end
        if (sc_re) begin
            r_sc_q <= sc_mem[sc_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fx_we) begin
            fx_mem[addr_ext[EA_W-1:0]] <= r_req_word;
        end
        if (fx_re) begin
            r_fx_q <= fx_mem[fx_raddr];
        end
    end

    // A tick request always starts with the phase pass.
    a_tick_to_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_operation == OP_TICK)) |=> (r_state == S_PHASE))
        else $error("tick request did not start the phase pass");

    // A sample is only published from the final state of a tick.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("output valid rose outside the final tick state");

    // The score only starts playing from a start request.
    a_score_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sc_playing) |-> ($past(r_state == S_REDUCE)
                                 && $past(r_req_op == OP_START_SCORE)))
        else $error("score playback began without a start request");

    // No more than two score entries are read in one tick.
    a_two_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SC_EVAL && r_sc_reads) |=> (r_state == S_FX_CHK))
        else $error("third score read attempted in one tick");

    // Store reads never happen outside a tick.
    a_read_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sc_re || fx_re) |-> !(r_state == S_IDLE || r_state == S_REDUCE))
        else $error("store read issued outside a tick");

endmodule

`default_nettype wire
